// ===== rtl/keyframe_curve_interpolator_macros.svh =====
// Assertion macros shared by the keyframe curve interpolator RTL.
`ifndef KEYFRAME_CURVE_INTERPOLATOR_MACROS_SVH
`define KEYFRAME_CURVE_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KCI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KCI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kci_pkg.sv =====
// Shared types and constants of the keyframe curve interpolator.
package kci_pkg;

    localparam int MAX_KEYS_DEF = 16;

    localparam int TIME_W  = 17;  // Q2.15 input time
    localparam int STIME_W = 18;  // stored key time
    localparam int VAL_W   = 16;  // Q8.8 value
    localparam int DT_W    = 17;  // offset and span magnitudes
    localparam int Q_W     = 17;  // quotient bits
    localparam int PROD_W  = VAL_W + DT_W;

    localparam logic signed [VAL_W-1:0]   ONE_Q8_8  = 16'sd256;
    localparam logic signed [STIME_W-1:0] ONE_Q2_15 = 18'sd32768;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_EVAL   = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        RES_ZERO,
        RES_ONE,
        RES_FULL,
        RES_CUR,
        RES_PREV,
        RES_INTERP
    } res_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_TEST,
        S_INS_RD,
        S_INS_CMP,
        S_EV_RD,
        S_EV_CMP,
        S_MUL,
        S_DIV,
        S_DIV_WAIT,
        S_OUT
    } state_t;

    typedef struct packed {
        logic     load_in;
        logic     clr_count;
        logic     inc_count;
        logic     idx_load_count;
        logic     idx_clr;
        logic     idx_inc;
        logic     idx_dec;
        logic     rd_prev;
        logic     we;
        logic     wr_new;
        logic     save_prev;
        logic     seg_load;
        logic     mul_load;
        logic     div_start;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } kci_cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       count_zero;
        logic       full;
        logic       idx_zero;
        logic       idx_last;
        logic       cur_ge_t;
        logic       cur_gt_t;
        logic       prev_eq_t;
        logic       ins_shift;
        logic       div_done;
    } kci_sts_t;

endpackage

// ===== rtl/kci_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module kci_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/kci_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module kci_div
    import kci_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] num,
    input  logic [DT_W-1:0]   den,
    output logic [Q_W-1:0]    quot,
    output logic              done
);

    localparam int CNT_W = $clog2(Q_W + 1);

    logic [Q_W-1:0]   rem_reg, rem_next;
    logic [Q_W-1:0]   low_reg, low_next;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [Q_W:0] shifted;
    logic [Q_W:0] trial;
    logic         ge;

    always_comb
    begin
        shifted   = {rem_reg, low_reg[Q_W-1]};
        trial     = shifted - {1'b0, den};
        ge        = (shifted >= {1'b0, den});
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start)
        begin
            // The quotient fits in Q_W bits, so the upper part of the
            // numerator is already below the divisor.
            rem_next  = Q_W'(num[PROD_W-1:Q_W]);
            low_next  = num[Q_W-1:0];
            q_next    = '0;
            cnt_next  = CNT_W'(Q_W);
            busy_next = 1'b1;
            done_next = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[Q_W-1:0] : shifted[Q_W-1:0];
            low_next = {low_reg[Q_W-2:0], 1'b0};
            q_next   = {q_reg[Q_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

// ===== rtl/kci_ctrl.sv =====
// Controller state machine of the keyframe curve interpolator.
module kci_ctrl
    import kci_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  kci_sts_t sts,
    output kci_cmd_t cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_OUT;
                unique case (sts.op)
                    OP_CLEAR:
                    begin
                        cmd.clr_count = 1'b1;
                        cmd.res_load  = 1'b1;
                        cmd.res_sel   = RES_ZERO;
                    end
                    OP_INSERT:
                    begin
                        if (sts.full)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_FULL;
                        end
                        else
                        begin
                            cmd.idx_load_count = 1'b1;
                            state_next         = S_INS_TEST;
                        end
                    end
                    OP_EVAL:
                    begin
                        if (sts.count_zero)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_ONE;
                        end
                        else
                        begin
                            cmd.idx_clr = 1'b1;
                            state_next  = S_EV_RD;
                        end
                    end
                    default:
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ZERO;
                    end
                endcase
            end
            S_INS_TEST:
            begin
                if (sts.idx_zero)
                begin
                    cmd.we        = 1'b1;
                    cmd.wr_new    = 1'b1;
                    cmd.inc_count = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_sel   = RES_ZERO;
                    state_next    = S_OUT;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                cmd.rd_prev = 1'b1;
                state_next  = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                cmd.we = 1'b1;
                if (sts.ins_shift)
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_INS_TEST;
                end
                else
                begin
                    cmd.wr_new    = 1'b1;
                    cmd.inc_count = 1'b1;
                    cmd.res_load  = 1'b1;
                    cmd.res_sel   = RES_ZERO;
                    state_next    = S_OUT;
                end
            end
            S_EV_RD:
            begin
                state_next = S_EV_CMP;
            end
            S_EV_CMP:
            begin
                priority if (sts.cur_ge_t && sts.idx_zero)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_CUR;
                    state_next   = S_OUT;
                end
                else if (sts.prev_eq_t)
                begin
                    // Inside a run of keys that sit exactly at t; the first of them is
                    // held as the previous key. The last key wins only if the run ends
                    // the table.
                    priority if (sts.cur_gt_t)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_PREV;
                        state_next   = S_OUT;
                    end
                    else if (sts.idx_last)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_CUR;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_EV_RD;
                    end
                end
                else if (sts.cur_gt_t)
                begin
                    cmd.seg_load = 1'b1;
                    state_next   = S_MUL;
                end
                else if (sts.idx_last)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_CUR;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.save_prev = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_EV_RD;
                end
            end
            S_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = RES_INTERP;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/kci_dp.sv =====
// Datapath of the keyframe curve interpolator: key table, arithmetic, result registers.
module kci_dp
    import kci_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  kci_cmd_t                  cmd,
    output kci_sts_t                  sts,
    input  logic [1:0]                op,
    input  logic signed [TIME_W-1:0]  key_time,
    input  logic signed [VAL_W-1:0]   key_value,
    input  logic signed [TIME_W-1:0]  eval_time,
    output logic signed [VAL_W-1:0]   curve_value,
    output logic                      status
);

    localparam int CNT_W   = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W  = $clog2(MAX_KEYS);
    localparam int ENTRY_W = STIME_W + VAL_W;

    logic [1:0]                op_reg;
    logic signed [STIME_W-1:0] key_t_reg;
    logic signed [VAL_W-1:0]   key_v_reg;
    logic signed [STIME_W-1:0] evt_reg, evt_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          idx_reg;
    logic signed [STIME_W-1:0] prev_t_reg;
    logic signed [VAL_W-1:0]   prev_v_reg;
    logic [VAL_W-1:0]          diff_mag_reg, diff_mag_next;
    logic                      neg_reg;
    logic [DT_W-1:0]           dt_reg;
    logic [DT_W-1:0]           span_reg;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic signed [VAL_W-1:0]   res_v_reg, res_v_next;
    logic                      res_s_reg, res_s_next;
    logic signed [VAL_W-1:0]   out_v_reg;
    logic                      out_s_reg;

    logic [CNT_W-1:0]          idx_m1;
    logic [ADDR_W-1:0]         raddr;
    logic [ENTRY_W-1:0]        wdata;
    logic [ENTRY_W-1:0]        rdata;
    logic signed [STIME_W-1:0] rd_t;
    logic signed [VAL_W-1:0]   rd_v;
    logic signed [VAL_W:0]     diff_s;
    logic signed [STIME_W-1:0] dt_s;
    logic signed [STIME_W-1:0] span_s;
    logic signed [STIME_W-1:0] et_ext;
    logic [Q_W-1:0]            quot;
    logic                      div_done;
    logic signed [VAL_W+1:0]   interp;

    assign idx_m1 = idx_reg - CNT_W'(1);
    assign raddr  = cmd.rd_prev ? idx_m1[ADDR_W-1:0] : idx_reg[ADDR_W-1:0];
    assign wdata  = cmd.wr_new ? {key_t_reg, key_v_reg} : rdata;
    assign rd_t   = rdata[ENTRY_W-1:VAL_W];
    assign rd_v   = rdata[VAL_W-1:0];

    kci_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_keys (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (idx_reg[ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    kci_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (prod_reg),
        .den   (span_reg),
        .quot  (quot),
        .done  (div_done)
    );

    // Clamp t to 0.0 .. 1.0.
    always_comb
    begin
        et_ext = STIME_W'(eval_time);
        priority if (et_ext < 0)
        begin
            evt_next = '0;
        end
        else if (et_ext > ONE_Q2_15)
        begin
            evt_next = ONE_Q2_15;
        end
        else
        begin
            evt_next = et_ext;
        end
    end

    always_comb
    begin
        diff_s        = (VAL_W+1)'(rd_v) - (VAL_W+1)'(prev_v_reg);
        diff_mag_next = diff_s[VAL_W] ? VAL_W'(-diff_s) : VAL_W'(diff_s);
        dt_s          = evt_reg - prev_t_reg;
        span_s        = rd_t - prev_t_reg;
        prod_next     = PROD_W'(diff_mag_reg) * PROD_W'(dt_reg);
        interp        = neg_reg ? ((VAL_W+2)'(prev_v_reg) - (VAL_W+2)'(quot))
                                : ((VAL_W+2)'(prev_v_reg) + (VAL_W+2)'(quot));
    end

    always_comb
    begin
        res_v_next = '0;
        res_s_next = 1'b0;
        unique case (cmd.res_sel)
            RES_ZERO:   res_v_next = '0;
            RES_ONE:    res_v_next = ONE_Q8_8;
            RES_FULL:   res_s_next = 1'b1;
            RES_CUR:    res_v_next = rd_v;
            RES_PREV:   res_v_next = prev_v_reg;
            RES_INTERP: res_v_next = interp[VAL_W-1:0];
            default:    res_v_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            op_reg    <= '0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                op_reg <= op;
            end
            priority if (cmd.clr_count)
            begin
                count_reg <= '0;
            end
            else if (cmd.inc_count)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            priority if (cmd.idx_load_count)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.idx_clr)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_m1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            key_t_reg <= STIME_W'(key_time);
            key_v_reg <= key_value;
            evt_reg   <= evt_next;
        end
        if (cmd.save_prev)
        begin
            prev_t_reg <= rd_t;
            prev_v_reg <= rd_v;
        end
        if (cmd.seg_load)
        begin
            diff_mag_reg <= diff_mag_next;
            neg_reg      <= diff_s[VAL_W];
            dt_reg       <= dt_s[DT_W-1:0];
            span_reg     <= span_s[DT_W-1:0];
        end
        if (cmd.mul_load)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.res_load)
        begin
            res_v_reg <= res_v_next;
            res_s_reg <= res_s_next;
        end
        if (cmd.out_load)
        begin
            out_v_reg <= res_v_reg;
            out_s_reg <= res_s_reg;
        end
    end

    assign sts.op         = op_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.full       = (count_reg == CNT_W'(MAX_KEYS));
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.idx_last   = (idx_reg == count_reg - CNT_W'(1));
    assign sts.cur_ge_t   = (rd_t >= evt_reg);
    assign sts.cur_gt_t   = (rd_t > evt_reg);
    // The previous key is only meaningful once the scan has moved past slot 0.
    assign sts.prev_eq_t  = (idx_reg != '0) && (prev_t_reg == evt_reg);
    assign sts.ins_shift  = (rd_t > key_t_reg);
    assign sts.div_done   = div_done;

    assign curve_value = out_v_reg;
    assign status      = out_s_reg;

endmodule

// ===== rtl/keyframe_curve_interpolator.sv =====
// Top level of the keyframe curve interpolator: controller, datapath and checks.
//
// The input channel carries one command beat: op with key_time, key_value and eval_time.
// Clear empties the key table, insert adds a key in time order (stable for equal times),
// evaluate returns the piecewise linear value of the curve at t clamped to 0.0 .. 1.0.
// Every input beat produces exactly one output beat on curve_value and status; status is
// high only when an insert finds the table full, and curve_value is zero except for
// evaluate. Both channels use a valid/ready handshake.
//
// One command is processed at a time. Clear, unused codes, a dropped insert and an evaluate of
// an empty table go from decode straight to the output stage. An insert moves each later key
// up one slot and then writes the new key; an evaluate reads the keys in order, and an
// interpolation adds the multiply and the 17-step bit-serial divide. in_ready returns as the
// result enters the output register. If the receiver stalls, the result waits in the output
// register while the next command is taken and worked on, holding its own result until the
// slot frees. Reset empties the key table and drops any pending output beat; key RAM contents
// are not cleared, as entries past the key count are never read.
`include "keyframe_curve_interpolator_macros.svh"

module keyframe_curve_interpolator
    import kci_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               op,
    input  logic signed [TIME_W-1:0] key_time,
    input  logic signed [VAL_W-1:0]  key_value,
    input  logic signed [TIME_W-1:0] eval_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [VAL_W-1:0]  curve_value,
    output logic                     status
);

    kci_cmd_t cmd;
    kci_sts_t sts;

    // The controller sequences each command; the datapath owns every data register.
    kci_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    kci_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .op          (op),
        .key_time    (key_time),
        .key_value   (key_value),
        .eval_time   (eval_time),
        .curve_value (curve_value),
        .status      (status)
    );

    // The key count must never grow past the table size.
    `KCI_ASSERT_NOW(a_no_overfill, clk, rst_n, cmd.inc_count, !sts.full,
        "key count incremented on a full table")

    // A result must never overwrite an output beat that has not been taken.
    `KCI_ASSERT_NOW(a_no_out_overwrite, clk, rst_n, cmd.out_load, !out_valid || out_ready,
        "output register loaded while holding an untaken beat")

    // Only one command is in flight: an accept closes the input channel.
    `KCI_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready,
        "input accepted while a command is still in progress")

endmodule

// ===== test/tb_keyframe_curve_interpolator.sv =====
// Self-checking testbench for the keyframe curve interpolator.
`timescale 1ns / 1ps

module tb_keyframe_curve_interpolator;
    import kci_pkg::*;

    // Op code 3 has no meaning in the block; it must still give one zero beat.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles with no beat on either channel before the run is declared hung.
    // The limit lies well above the slowest command and the longest deliberate
    // hold-off, so this leaves a wide margin.
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_ITEMS  = 250;

    // One expected output beat.
    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic                    dropped;
    } curve_beat_t;

    // Keeps a private copy of the key table, works out the beat that each accepted
    // command must produce, and compares the beats that come back in order.
    class keyframe_book;
        logic signed [STIME_W-1:0] key_times [MAX_KEYS_DEF];
        logic signed [VAL_W-1:0]   key_vals  [MAX_KEYS_DEF];
        int                        key_total;
        curve_beat_t               awaited [$];
        int errors;
        int commands;
        int beats;
        int evals;
        int drops;

        function new();
            key_total = 0;
            errors    = 0;
            commands  = 0;
            beats     = 0;
            evals     = 0;
            drops     = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH: %s", $realtime, what);
            errors++;
        endtask

        // Stable insert: the new key goes after every key of equal or lower time.
        function void add_key(logic signed [TIME_W-1:0] t, logic signed [VAL_W-1:0] v);
            int slot;
            slot = 0;
            while (slot < key_total && key_times[slot] <= t)
                slot++;
            for (int i = key_total; i > slot; i--)
            begin
                key_times[i] = key_times[i-1];
                key_vals[i]  = key_vals[i-1];
            end
            key_times[slot] = t;
            key_vals[slot]  = v;
            key_total++;
        endfunction

        function logic signed [VAL_W-1:0] curve_at(logic signed [TIME_W-1:0] t_in);
            int     t;
            int     last;
            longint span;
            longint num;
            if (key_total == 0)
                return ONE_Q8_8;
            if (key_total == 1)
                return key_vals[0];
            t = t_in;
            if (t < 0)
                t = 0;
            if (t > ONE_Q2_15)
                t = ONE_Q2_15;
            last = key_total - 1;
            if (t <= key_times[0])
                return key_vals[0];
            if (t >= key_times[last])
                return key_vals[last];
            for (int i = 0; i < last; i++)
            begin
                if (t < key_times[i] || t > key_times[i+1])
                    continue;
                span = longint'(key_times[i+1]) - longint'(key_times[i]);
                if (span <= 0)
                    return key_vals[i+1];
                num = (longint'(key_vals[i+1]) - longint'(key_vals[i])) *
                      (longint'(t) - longint'(key_times[i]));
                // SystemVerilog division of signed integers truncates toward zero.
                return VAL_W'(longint'(key_vals[i]) + num / span);
            end
            return key_vals[last];
        endfunction

        function void note_command(logic [1:0] c_op, logic signed [TIME_W-1:0] kt,
                                   logic signed [VAL_W-1:0] kv,
                                   logic signed [TIME_W-1:0] et);
            curve_beat_t b;
            b.value   = '0;
            b.dropped = 1'b0;
            commands++;
            if (c_op == OP_CLEAR)
                key_total = 0;
            else if (c_op == OP_INSERT)
            begin
                if (key_total >= MAX_KEYS_DEF)
                begin
                    b.dropped = 1'b1;
                    drops++;
                end
                else
                    add_key(kt, kv);
            end
            else if (c_op == OP_EVAL)
            begin
                b.value = curve_at(et);
                evals++;
            end
            awaited.push_back(b);
        endfunction

        task check_beat(logic signed [VAL_W-1:0] got_value, logic got_status);
            curve_beat_t b;
            beats++;
            if (awaited.size() == 0)
                report($sformatf("output beat value=%0d status=%0b with nothing expected",
                                 got_value, got_status));
            else
            begin
                b = awaited.pop_front();
                if (got_value !== b.value)
                    report($sformatf("beat %0d curve_value %0d, expected %0d",
                                     beats, got_value, b.value));
                if (got_status !== b.dropped)
                    report($sformatf("beat %0d status %0b, expected %0b",
                                     beats, got_status, b.dropped));
            end
        endtask
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [1:0]                 op        = OP_CLEAR;
    logic signed [TIME_W-1:0]   key_time  = '0;
    logic signed [VAL_W-1:0]    key_value = '0;
    logic signed [TIME_W-1:0]   eval_time = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [VAL_W-1:0]    curve_value;
    logic                       status;

    // Idle mix for each side, in percent of cycles, changed between phases.
    int send_idle_pct  = 14;
    int recv_stall_pct = 69;
    // When nonzero, the receiver keeps out_ready low for this many more cycles.
    int hold_left      = 0;
    int quiet_cycles   = 0;

    keyframe_book book = new();

    keyframe_curve_interpolator #(
        .MAX_KEYS(MAX_KEYS_DEF)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .key_time(key_time),
        .key_value(key_value),
        .eval_time(eval_time),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .curve_value(curve_value),
        .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: random stalls, or a long counted hold-off when one is requested.
    // The hold-off is what lets the block fill its output slot and its working
    // command, so that in_ready has to drop while the sender keeps offering.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Both channels are sampled at the rising edge, before any of this edge's
    // nonblocking updates land, so the values seen are the ones the block sees.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                book.check_beat(curve_value, status);
            if (in_valid && in_ready)
                book.note_command(op, key_time, key_value, eval_time);
        end
    end

    // Watchdog: ends the run if neither channel moves a beat for too long.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Timeout: no beat moved for %0d cycles, %0d results outstanding.",
                 QUIET_LIMIT, book.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // Offers one command beat and returns at the edge where it is accepted.
    // in_valid is left high so a following command can follow back to back.
    task automatic offer_command(input logic [1:0] c_op,
                                 input logic signed [TIME_W-1:0] kt,
                                 input logic signed [VAL_W-1:0] kv,
                                 input logic signed [TIME_W-1:0] et);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= c_op;
        key_time  <= kt;
        key_value <= kv;
        eval_time <= et;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drops valid and waits until every issued command has produced its beat.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    // Times are drawn in three ways: around the 0 .. 1.0 window, on a coarse grid
    // so that evaluations land exactly on key times and keys share times, and
    // over the whole field so that every bit toggles.
    function automatic logic signed [TIME_W-1:0] pick_time();
        int x;
        int mode;
        mode = $urandom_range(9);
        if (mode < 4)
            x = int'($urandom_range(36864)) - 2048;
        else if (mode < 7)
            x = int'($urandom_range(18)) * 2048 - 2048;
        else
            x = $urandom;
        return x[TIME_W-1:0];
    endfunction

    // Mostly inserts and evaluates, so the table grows to full and gets
    // evaluated at every size; clears restart it and op 3 is mixed in as noise.
    task automatic offer_random();
        int         pick;
        logic [1:0] c_op;
        pick = $urandom_range(99);
        if (pick < 5)
            c_op = OP_CLEAR;
        else if (pick < 9)
            c_op = OP_UNUSED;
        else if (pick < 47)
            c_op = OP_INSERT;
        else
            c_op = OP_EVAL;
        offer_command(c_op, pick_time(), VAL_W'($urandom), pick_time());
    endtask

    task automatic offer_random_run(input int count);
        for (int i = 0; i < count; i++)
            offer_random();
    endtask

    // Directed opening: empty table, op 3, a single key, then a full table built
    // from the field extremes and repeated times, an overflow, and evaluations
    // below, above, between and exactly on keys.
    task automatic offer_directed();
        offer_command(OP_EVAL, 17'sd0, 16'sd0, 17'sd0);
        offer_command(OP_UNUSED, 17'sd5, 16'sd5, 17'sd5);
        offer_command(OP_INSERT, 17'sd16384, -16'sd32768, 17'sd0);
        offer_command(OP_EVAL, 17'sd0, 16'sd0, -17'sd65536);
        offer_command(OP_CLEAR, 17'sd0, 16'sd0, 17'sd0);
        offer_command(OP_INSERT, -17'sd65536, 16'sd32767, 17'sd0);
        offer_command(OP_INSERT, 17'sd0, 16'sd100, 17'sd0);
        offer_command(OP_INSERT, 17'sd0, -16'sd100, 17'sd0);
        offer_command(OP_INSERT, 17'sd8192, -16'sd32768, 17'sd0);
        offer_command(OP_INSERT, 17'sd16384, 16'sd32767, 17'sd0);
        offer_command(OP_INSERT, 17'sd16384, 16'sd0, 17'sd0);
        offer_command(OP_INSERT, 17'sd32768, 16'sd256, 17'sd0);
        offer_command(OP_INSERT, 17'sd65535, -16'sd1, 17'sd0);
        offer_command(OP_INSERT, 17'sd4096, 16'sd1000, 17'sd0);
        offer_command(OP_INSERT, 17'sd12000, -16'sd5000, 17'sd0);
        offer_command(OP_INSERT, 17'sd20000, 16'sd7777, 17'sd0);
        offer_command(OP_INSERT, 17'sd24576, -16'sd20000, 17'sd0);
        offer_command(OP_INSERT, 17'sd28000, 16'sd30000, 17'sd0);
        offer_command(OP_INSERT, 17'sd30000, -16'sd30000, 17'sd0);
        offer_command(OP_INSERT, 17'sd32767, 16'sd5, 17'sd0);
        offer_command(OP_INSERT, 17'sd40000, 16'sd123, 17'sd0);
        // The table now holds 16 keys, so this one must be dropped.
        offer_command(OP_INSERT, 17'sd1000, 16'sd1, 17'sd0);
        offer_command(OP_EVAL, 17'sd0, 16'sd0, -17'sd65536);
        offer_command(OP_EVAL, 17'sd0, 16'sd0, 17'sd65535);
        offer_command(OP_EVAL, 17'sd0, 16'sd0, 17'sd16384);
        offer_command(OP_EVAL, 17'sd0, 16'sd0, 17'sd2000);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase one: sender mostly busy, receiver mostly stalled.
        send_idle_pct  = 14;
        recv_stall_pct = 69;
        offer_directed();
        offer_random_run(PHASE_ITEMS);
        // The sender pauses here until the block has answered everything.
        wait_for_results();

        // Phase two: the roles swap.
        send_idle_pct  = 69;
        recv_stall_pct = 14;
        offer_random_run(PHASE_ITEMS);

        // Phase three: no idling, opened by a long receiver hold-off during
        // which the sender keeps offering and the block must back-pressure it.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        offer_random_run(PHASE_ITEMS);

        wait_for_results();
        // Any beat that shows up now has no command behind it and is flagged.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d commands through three idle mixes and a %0d-cycle output hold-off.",
                 book.commands, HOLD_CYCLES);
        $display("Checked %0d result beats: %0d evaluates, %0d inserts dropped on a full table.",
                 book.beats, book.evals, book.drops);
        if (book.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
